// ===== hdl/bbl_pkg.sv =====
package bbl_pkg;

    localparam int BYTE_WIDTH    = 8;
    localparam int CFG_IDX_WIDTH = 3;
    localparam int NUM_PAIRS     = 3;
    localparam int NUM_COUNTERS  = 2 * NUM_PAIRS;
    localparam int EXCESS_WIDTH  = 25;
    localparam int LINES_WIDTH   = 24;
    localparam int EXCESS_LIMIT  = 16777215;
    localparam int LINES_LIMIT   = 16777215;

    localparam logic [BYTE_WIDTH-1:0] CH_SLASH  = 8'h2F;
    localparam logic [BYTE_WIDTH-1:0] CH_STAR   = 8'h2A;
    localparam logic [BYTE_WIDTH-1:0] CH_DQUOTE = 8'h22;
    localparam logic [BYTE_WIDTH-1:0] CH_SQUOTE = 8'h27;
    localparam logic [BYTE_WIDTH-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_WIDTH-1:0] CH_NL     = 8'h0A;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_BRACE_OPEN    = 3'd0,
        CFG_BRACE_CLOSE   = 3'd1,
        CFG_BRACKET_OPEN  = 3'd2,
        CFG_BRACKET_CLOSE = 3'd3,
        CFG_PAREN_OPEN    = 3'd4,
        CFG_PAREN_CLOSE   = 3'd5
    } t_cfg_idx;

    typedef logic [BYTE_WIDTH-1:0] t_byte;

    localparam t_byte CFG_RESET [NUM_COUNTERS] = '{8'd123, 8'd125, 8'd91, 8'd93, 8'd40, 8'd41};

endpackage

// ===== hdl/bbl_scanner.sv =====
module bbl_scanner
    import bbl_pkg::*;
#(
    parameter int COUNT_WIDTH = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0] i_cfg_index,
    input  logic [BYTE_WIDTH-1:0]    i_cfg_data,
    input  logic                     i_accept,
    input  logic [BYTE_WIDTH-1:0]    i_text_byte,
    input  logic                     i_end_of_text,
    output logic                     o_done,
    output logic [COUNT_WIDTH-1:0]   o_cnt [NUM_COUNTERS],
    output logic [COUNT_WIDTH-1:0]   o_lines
);

    t_byte r_cfg [NUM_COUNTERS];

    logic r_in_line, r_in_block, r_in_string, r_in_char;
    logic n_in_line, n_in_block, n_in_string, n_in_char;
    t_byte r_prev, r_prev2;
    logic [COUNT_WIDTH-1:0] r_cnt [NUM_COUNTERS];
    logic [COUNT_WIDTH-1:0] n_cnt [NUM_COUNTERS];
    logic [COUNT_WIDTH-1:0] r_lines, n_lines;
    logic count_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BRACE_OPEN:    r_cfg[CFG_BRACE_OPEN]    <= i_cfg_data;
                CFG_BRACE_CLOSE:   r_cfg[CFG_BRACE_CLOSE]   <= i_cfg_data;
                CFG_BRACKET_OPEN:  r_cfg[CFG_BRACKET_OPEN]  <= i_cfg_data;
                CFG_BRACKET_CLOSE: r_cfg[CFG_BRACKET_CLOSE] <= i_cfg_data;
                CFG_PAREN_OPEN:    r_cfg[CFG_PAREN_OPEN]    <= i_cfg_data;
                CFG_PAREN_CLOSE:   r_cfg[CFG_PAREN_CLOSE]   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // mode updates run in order, each sees the flags left by the one before
    always_comb begin
        n_in_line   = r_in_line;
        n_in_block  = r_in_block;
        n_in_string = r_in_string;
        n_in_char   = r_in_char;
        if (!n_in_string && !n_in_block && !n_in_char) begin
            if (i_text_byte == CH_SLASH && r_prev == CH_SLASH && !n_in_line)
                n_in_line = 1'b1;
            else if (i_text_byte == CH_NL && n_in_line)
                n_in_line = 1'b0;
        end
        if (!n_in_string && !n_in_line && !n_in_char) begin
            if (r_prev == CH_SLASH && i_text_byte == CH_STAR && !n_in_block)
                n_in_block = 1'b1;
            else if (r_prev == CH_STAR && i_text_byte == CH_SLASH && n_in_block)
                n_in_block = 1'b0;
        end
        if (!n_in_line && !n_in_block && !n_in_char) begin
            if (i_text_byte == CH_DQUOTE && !n_in_string)
                n_in_string = 1'b1;
            else if (r_prev != CH_BSLASH && i_text_byte == CH_DQUOTE)
                n_in_string = 1'b0;
        end
        if (!n_in_string && !n_in_line && !n_in_block) begin
            if (i_text_byte == CH_SQUOTE && !n_in_char)
                n_in_char = 1'b1;
            else if ((r_prev != CH_BSLASH && i_text_byte == CH_SQUOTE) ||
                     (r_prev2 == CH_BSLASH && r_prev == CH_BSLASH &&
                      i_text_byte == CH_SQUOTE))
                n_in_char = 1'b0;
        end
        count_en = !n_in_line && !n_in_string && !n_in_block && !n_in_char;

        // open byte wins when a pair uses the same byte for both
        for (int k = 0; k < NUM_PAIRS; k++) begin
            n_cnt[2*k]   = r_cnt[2*k];
            n_cnt[2*k+1] = r_cnt[2*k+1];
            if (count_en && i_text_byte == r_cfg[2*k]) begin
                if (!(&r_cnt[2*k]))
                    n_cnt[2*k] = r_cnt[2*k] + COUNT_WIDTH'(1);
            end else if (count_en && i_text_byte == r_cfg[2*k+1]) begin
                if (!(&r_cnt[2*k+1]))
                    n_cnt[2*k+1] = r_cnt[2*k+1] + COUNT_WIDTH'(1);
            end
        end
        n_lines = r_lines;
        if (i_text_byte == CH_NL && !(&r_lines))
            n_lines = r_lines + COUNT_WIDTH'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_end_of_text)) begin
            r_in_line   <= 1'b0;
            r_in_block  <= 1'b0;
            r_in_string <= 1'b0;
            r_in_char   <= 1'b0;
            r_prev      <= '0;
            r_prev2     <= '0;
            r_lines     <= '0;
            for (int i = 0; i < NUM_COUNTERS; i++)
                r_cnt[i] <= '0;
        end else if (i_accept) begin
            r_in_line   <= n_in_line;
            r_in_block  <= n_in_block;
            r_in_string <= n_in_string;
            r_in_char   <= n_in_char;
            r_prev      <= i_text_byte;
            r_prev2     <= r_prev;
            r_lines     <= n_lines;
            r_cnt       <= n_cnt;
        end
    end

    assign o_done  = i_accept && i_end_of_text;
    assign o_cnt   = n_cnt;
    assign o_lines = n_lines;

endmodule

// ===== hdl/bbl_result.sv =====
module bbl_result
    import bbl_pkg::*;
#(
    parameter int COUNT_WIDTH = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_done,
    input  logic [COUNT_WIDTH-1:0]         i_cnt [NUM_COUNTERS],
    input  logic [COUNT_WIDTH-1:0]         i_lines,
    output logic                           o_full,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_balanced,
    output logic signed [EXCESS_WIDTH-1:0] o_brace_excess,
    output logic signed [EXCESS_WIDTH-1:0] o_bracket_excess,
    output logic signed [EXCESS_WIDTH-1:0] o_paren_excess,
    output logic [LINES_WIDTH-1:0]         o_lines_seen
);

    localparam int WIDE = (COUNT_WIDTH > LINES_WIDTH) ? COUNT_WIDTH : LINES_WIDTH;
    localparam int DW   = WIDE + 2;

    logic                   r_snap_valid;
    logic [COUNT_WIDTH-1:0] r_snap_cnt [NUM_COUNTERS];
    logic [COUNT_WIDTH-1:0] r_snap_lines;
    logic                   out_load;

    logic signed [DW-1:0]           diff [NUM_PAIRS];
    logic signed [EXCESS_WIDTH-1:0] n_excess [NUM_PAIRS];
    logic [WIDE-1:0]                lines_ext;
    logic [LINES_WIDTH-1:0]         n_lines_seen;
    logic                           n_balanced;

    logic                           r_out_valid;
    logic                           r_balanced;
    logic signed [EXCESS_WIDTH-1:0] r_excess [NUM_PAIRS];
    logic [LINES_WIDTH-1:0]         r_lines_seen;

    assign out_load = !r_out_valid || !i_out_stall;
    assign o_full   = r_snap_valid && !out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (i_done) begin
            r_snap_valid <= 1'b1;
        end else if (out_load) begin
            r_snap_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_done) begin
            r_snap_cnt   <= i_cnt;
            r_snap_lines <= i_lines;
        end
    end

    // signed difference per pair, clamped to the excess field range
    always_comb begin
        n_balanced = 1'b1;
        for (int k = 0; k < NUM_PAIRS; k++) begin
            diff[k] = $signed({{(DW-COUNT_WIDTH){1'b0}}, r_snap_cnt[2*k]}) -
                      $signed({{(DW-COUNT_WIDTH){1'b0}}, r_snap_cnt[2*k+1]});
            if (diff[k] > $signed(DW'(EXCESS_LIMIT)))
                n_excess[k] = EXCESS_WIDTH'(EXCESS_LIMIT);
            else if (diff[k] < -$signed(DW'(EXCESS_LIMIT)))
                n_excess[k] = -EXCESS_WIDTH'(EXCESS_LIMIT);
            else
                n_excess[k] = diff[k][EXCESS_WIDTH-1:0];
            if (r_snap_cnt[2*k] != r_snap_cnt[2*k+1])
                n_balanced = 1'b0;
        end
        lines_ext = WIDE'(r_snap_lines);
        if (lines_ext > WIDE'(LINES_LIMIT))
            n_lines_seen = LINES_WIDTH'(LINES_LIMIT);
        else
            n_lines_seen = lines_ext[LINES_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_snap_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_snap_valid) begin
            r_balanced   <= n_balanced;
            r_excess     <= n_excess;
            r_lines_seen <= n_lines_seen;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_balanced       = r_balanced;
    assign o_brace_excess   = r_excess[0];
    assign o_bracket_excess = r_excess[1];
    assign o_paren_excess   = r_excess[2];
    assign o_lines_seen     = r_lines_seen;

endmodule

// ===== hdl/bracket_balance_lexer.sv =====
// Scans source text at one byte per cycle, tracking line comments, block
// comments, strings and character literals, and counts three configurable
// bracket pairs outside them plus every newline. The mode and counter update
// is a single registered step, so a byte can be accepted every cycle. The byte
// flagged end_of_text produces one result transaction via snapshot and output
// registers and clears the scan state; the input stalls only while a finished
// result waits behind a stalled output. The user must write configuration
// registers through the plain write port while the block is idle (unenforced).
module bracket_balance_lexer
    import bbl_pkg::*;
#(
    parameter int COUNT_WIDTH = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0]       i_cfg_index,
    input  logic [BYTE_WIDTH-1:0]          i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [BYTE_WIDTH-1:0]          i_text_byte,
    input  logic                           i_end_of_text,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_balanced,
    output logic signed [EXCESS_WIDTH-1:0] o_brace_excess,
    output logic signed [EXCESS_WIDTH-1:0] o_bracket_excess,
    output logic signed [EXCESS_WIDTH-1:0] o_paren_excess,
    output logic [LINES_WIDTH-1:0]         o_lines_seen
);

    logic                   accept;
    logic                   done;
    logic                   full;
    logic [COUNT_WIDTH-1:0] cnt [NUM_COUNTERS];
    logic [COUNT_WIDTH-1:0] lines;

    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    bbl_scanner #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_scanner (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (accept),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_done        (done),
        .o_cnt         (cnt),
        .o_lines       (lines)
    );

    bbl_result #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_result (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_done           (done),
        .i_cnt            (cnt),
        .i_lines          (lines),
        .o_full           (full),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_balanced       (o_balanced),
        .o_brace_excess   (o_brace_excess),
        .o_bracket_excess (o_bracket_excess),
        .o_paren_excess   (o_paren_excess),
        .o_lines_seen     (o_lines_seen)
    );

endmodule

// ===== hdl/bbl_checker.sv =====
module bbl_checker
    import bbl_pkg::*;
(
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic                           o_balanced,
    input logic signed [EXCESS_WIDTH-1:0] o_brace_excess,
    input logic signed [EXCESS_WIDTH-1:0] o_bracket_excess,
    input logic signed [EXCESS_WIDTH-1:0] o_paren_excess
);

    localparam logic [EXCESS_WIDTH-1:0] EXCESS_MIN_CODE = {1'b1, {(EXCESS_WIDTH-1){1'b0}}};

    // a waiting result is never withdrawn
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // input backs up only behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output backpressure");

    // balanced flag agrees with the three excess values
    a_balanced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_balanced == (o_brace_excess == '0 &&
                                        o_bracket_excess == '0 &&
                                        o_paren_excess == '0)))
        else $error("balanced flag disagrees with excess");

    // saturation never yields the most negative code
    a_excess_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_brace_excess != EXCESS_MIN_CODE &&
                         o_bracket_excess != EXCESS_MIN_CODE &&
                         o_paren_excess != EXCESS_MIN_CODE))
        else $error("excess out of range");

    // a stall after reset leaves a result waiting on the output
    a_stall_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> o_out_valid)
        else $error("stalled input with no pending result");

endmodule

bind bracket_balance_lexer bbl_checker u_bbl_checker (.*);
